// File: rtl/lfse_pkg.sv
// Shared types and constants for the link frame stuffing encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lfse_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_MASK     = 8'h20;
  localparam logic [7:0] ADDRESS_INIT = 8'h03;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified item handed from front to back.
  typedef struct packed {
    logic       sup;
    logic       hdr;
    logic       last;
    logic [7:0] data;
    logic [7:0] ctrl;
    logic [7:0] check;
  } desc_t;

  typedef enum logic [8:0] {
    S_FLAG  = 9'b000000001,
    S_ADDR  = 9'b000000010,
    S_CTRL  = 9'b000000100,
    S_HCHK  = 9'b000001000,
    S_DATA  = 9'b000010000,
    S_DESC  = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_CESC  = 9'b010000000,
    S_CLOSE = 9'b100000000
  } seq_state_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

// File: rtl/lfse_front.sv
// Front end: accepts input items, tracks frame state and running check.
// Depends on lfse_pkg; feeds lfse_fifo.
`timescale 1ns / 1ps

module lfse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        control_byte,
  input  logic              first,
  input  logic              last,
  input  logic              q_full,
  output logic              q_push,
  output lfse_pkg::desc_t   q_desc
);
  import lfse_pkg::*;

  logic       in_frame;
  logic       in_frame_next;
  logic [7:0] payload_check;
  logic [7:0] payload_check_next;
  logic [7:0] check_base;
  logic       open_hdr;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    open_hdr   = command || first || !in_frame;
    check_base = open_hdr ? 8'h00 : payload_check;

    q_desc.sup   = command;
    q_desc.hdr   = open_hdr;
    q_desc.last  = !command && last;
    q_desc.data  = data_byte;
    q_desc.ctrl  = control_byte;
    q_desc.check = check_base ^ data_byte;

    if (command || last) begin
      in_frame_next      = 1'b0;
      payload_check_next = 8'h00;
    end else begin
      in_frame_next      = 1'b1;
      payload_check_next = q_desc.check;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_check <= 8'h00;
    end else if (q_push) begin
      in_frame      <= in_frame_next;
      payload_check <= payload_check_next;
    end
  end

endmodule

// File: rtl/lfse_fifo.sv
// Short item queue between front and back ends.
// Depends on lfse_pkg for the item type and depth.
`timescale 1ns / 1ps

module lfse_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lfse_pkg::desc_t   push_desc,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output lfse_pkg::desc_t   pop_desc
);
  import lfse_pkg::*;

  desc_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_desc = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !nonempty |=> !$past(do_pop))
    else $error("pop from empty queue");

  a_pointers: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == QCNT_W'(QDEPTH)) || (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// File: rtl/lfse_back.sv
// Back end: sequences header, stuffed payload, check and flag bytes.
// Depends on lfse_pkg; drains lfse_fifo into the output register.
`timescale 1ns / 1ps

module lfse_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        address,
  input  logic              q_nonempty,
  input  lfse_pkg::desc_t   q_desc,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              end_of_run,
  output logic              end_of_frame
);
  import lfse_pkg::*;

  desc_t      cur;
  logic       busy;
  seq_state_t state;
  seq_state_t state_next;
  logic       adv;
  logic [7:0] emit_byte;
  logic       emit_eof;
  logic       finishing;
  logic       load;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    emit_byte  = FLAG_BYTE;
    emit_eof   = 1'b0;
    finishing  = 1'b0;
    state_next = state;
    unique case (state)
      S_FLAG: begin
        emit_byte  = FLAG_BYTE;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        emit_byte  = address;
        state_next = S_CTRL;
      end
      S_CTRL: begin
        emit_byte  = cur.ctrl;
        state_next = S_HCHK;
      end
      S_HCHK: begin
        emit_byte  = address ^ cur.ctrl;
        state_next = cur.sup ? S_CLOSE : S_DATA;
      end
      S_DATA: begin
        if (needs_escape(cur.data)) begin
          emit_byte  = ESC_BYTE;
          state_next = S_DESC;
        end else begin
          emit_byte  = cur.data;
          state_next = S_CHK;
          finishing  = !cur.last;
        end
      end
      S_DESC: begin
        emit_byte  = cur.data ^ ESC_MASK;
        state_next = S_CHK;
        finishing  = !cur.last;
      end
      S_CHK: begin
        if (needs_escape(cur.check)) begin
          emit_byte  = ESC_BYTE;
          state_next = S_CESC;
        end else begin
          emit_byte  = cur.check;
          state_next = S_CLOSE;
        end
      end
      S_CESC: begin
        emit_byte  = cur.check ^ ESC_MASK;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        emit_byte  = FLAG_BYTE;
        emit_eof   = 1'b1;
        finishing  = 1'b1;
        state_next = S_FLAG;
      end
      default: begin
        emit_byte  = FLAG_BYTE;
        state_next = S_FLAG;
      end
    endcase
  end

  assign load  = q_nonempty && (!busy || (adv && finishing));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      state <= S_FLAG;
    end else if (load) begin
      busy  <= 1'b1;
      state <= q_desc.hdr ? S_FLAG : S_DATA;
    end else if (busy && adv) begin
      busy  <= !finishing;
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && busy) begin
      out_byte     <= emit_byte;
      end_of_run   <= finishing;
      end_of_frame <= emit_eof;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot(state))
    else $error("sequencer state not one-hot");

  a_eof_is_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> (out_byte == FLAG_BYTE && end_of_run))
    else $error("closing flag malformed");

  a_escape_pair: assert property (@(posedge clk) disable iff (rst)
    (busy && (state == S_DESC || state == S_CESC))
      |-> (out_valid && out_byte == ESC_BYTE))
    else $error("escaped byte not preceded by escape");

endmodule

// File: rtl/link_frame_stuffing_encoder.sv
// Top level of the link frame stuffing encoder: front, queue and back.
// Depends on lfse_pkg, lfse_front, lfse_fifo and lfse_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     command, data_byte, control_byte, first, last
//   out      output     out_valid / out_stall   out_byte, end_of_run, end_of_frame
//   cfg      input      cfg_valid / cfg_ready   cfg_data (address byte)
//
// The back end emits one byte per cycle unless out_stall holds it; an item causes
// 1 or 2 bytes for a payload byte, plus 4 for a header and 1 to 3 for a close.
// The two-entry queue lets the front take a new item while the back is still busy.
// Reset (rst, synchronous) closes any frame, clears the check and sets address 0x03.
// out_stall holds the output register; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module link_frame_stuffing_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] data_byte,
  input  logic [7:0] control_byte,
  input  logic       first,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       end_of_run,
  output logic       end_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import lfse_pkg::*;

  logic [7:0] address;
  logic       q_full;
  logic       q_push;
  desc_t      push_desc;
  logic       q_pop;
  logic       q_nonempty;
  desc_t      pop_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address <= ADDRESS_INIT;
    end else if (cfg_valid && cfg_ready) begin
      address <= cfg_data;
    end
  end

  lfse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .control_byte (control_byte),
    .first        (first),
    .last         (last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (push_desc)
  );

  lfse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_desc  (pop_desc)
  );

  lfse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .address      (address),
    .q_nonempty   (q_nonempty),
    .q_desc       (pop_desc),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .end_of_run   (end_of_run),
    .end_of_frame (end_of_frame)
  );

endmodule
